// File: rtl/quaternion_to_euler_angles_defines.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Concurrent checks clocked on clk and disabled during rst; empty for SYNTH.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`ifndef SYNTH
`define QTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define QTE_ASSERT(lbl, prop)
`define QTE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: package
// Widths, constants, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES = 16;   // 8 .. 24
  localparam int TAB_LEN       = 24;

  localparam int IW    = 16;   // input and register width, Q1.15
  localparam int AW    = 17;   // remapped component (negated -32768)
  localparam int PRW   = 33;   // component times mount
  localparam int SUMW  = 36;
  localparam int PW    = 19;   // product quaternion component
  localparam int PPW   = 38;   // product of two components
  localparam int OPW   = 40;   // atan2 / asin operands, 30 fraction bits
  localparam int CW    = 43;   // CORDIC x/y
  localparam int ZW    = 32;   // CORDIC angle, 28 fraction bits
  localparam int SQ_STEPS = 31;
  localparam int RW    = 61;   // radicand
  localparam int SW    = 31;   // square root
  localparam int ANGW  = 16;
  localparam int PITW  = 15;
  localparam int CFG_IW = 2;

  localparam logic signed [OPW-1:0] ONE_Q30     = 40'sd1073741824;
  localparam logic signed [ZW-1:0]  PI_Q28      = 32'sd843314857;
  localparam logic signed [ZW-1:0]  ANG_MAX     = 32'sd25736;
  localparam logic signed [ZW-1:0]  HALF_PI_Q13 = 32'sd12868;
  localparam logic signed [ZW-1:0]  RND_Q13     = 32'sd16384;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MOUNT_QX,
    CFG_MOUNT_QY,
    CFG_MOUNT_QZ,
    CFG_MOUNT_QW
  } cfg_reg_t;

  // round(atan(2^-i) * 2^28)
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q4.28 angle to Q3.13, round half up
  function automatic logic signed [ZW-1:0] to_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = z + RND_Q13;
    return t >>> 15;
  endfunction

  function automatic logic signed [ZW-1:0] clamp_ang(input logic signed [ZW-1:0] v,
                                                     input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

// File: rtl/qte_channels.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: stream channels
// Valid/ready channels for the sensor quaternion and the Euler result.
// ----------------------------------------------------------------------------
interface qte_quat_if;
  logic valid;
  logic ready;
  logic signed [qte_pkg::IW-1:0] quat_x;
  logic signed [qte_pkg::IW-1:0] quat_y;
  logic signed [qte_pkg::IW-1:0] quat_z;
  logic signed [qte_pkg::IW-1:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if;
  logic valid;
  logic ready;
  logic signed [qte_pkg::ANGW-1:0] roll_angle;
  logic signed [qte_pkg::PITW-1:0] pitch_angle;
  logic signed [qte_pkg::ANGW-1:0] yaw_angle;
  logic                            pitch_saturated;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                output ready);
endinterface

// File: rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: pipelined CORDIC arctangent
// Vectoring mode, one rotation per stage after a registered half-plane fold.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [qte_pkg::CW-1:0]  x_in,
  input  logic signed [qte_pkg::CW-1:0]  y_in,
  output logic signed [qte_pkg::ZW-1:0]  z_out
);
  import qte_pkg::*;

  logic signed [CW-1:0] xs [CORDIC_STAGES+1];
  logic signed [CW-1:0] ys [CORDIC_STAGES+1];
  logic signed [ZW-1:0] zs [CORDIC_STAGES+1];
  logic                 zf [CORDIC_STAGES+1];

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= (y_in >= 0) ? PI_Q28 : -PI_Q28;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(i);
        end
      end
    end
  end

  // a zero vector reads as angle zero
  assign z_out = zf[CORDIC_STAGES] ? '0 : zs[CORDIC_STAGES];

endmodule

// File: rtl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: pipelined integer square root
// One result bit per stage, floor(sqrt(n)).
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [qte_pkg::RW-1:0] n_in,
  output logic [qte_pkg::SW-1:0] r_out
);
  import qte_pkg::*;

  logic [RW:0] nn [SQ_STEPS+1];
  logic [RW:0] rr [SQ_STEPS+1];

  assign nn[0] = {1'b0, n_in};
  assign rr[0] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam int K = SQ_STEPS - 1 - j;
    localparam logic [RW:0] BIT = (RW+1)'(1) << (2 * K);
    logic [RW:0] trial;
    assign trial = rr[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (nn[j] >= trial) begin
          nn[j+1] <= nn[j] - trial;
          rr[j+1] <= (rr[j] >> 1) + BIT;
        end else begin
          nn[j+1] <= nn[j];
          rr[j+1] <= rr[j] >> 1;
        end
      end
    end
  end

  assign r_out = rr[SQ_STEPS][SW-1:0];

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles (ZYX) with axis remap and mounting rotation
// Quaternion in; roll, yaw (Q3.13) and negated pitch (Q2.13) in radians out.
// ----------------------------------------------------------------------------
// The block takes one sensor quaternion per cycle while not stalled and
// returns one result per quaternion, in order. The whole datapath is one
// pipeline with a common advance: it holds while a finished result waits
// at the output and the sink is not ready, and otherwise moves by one stage
// each cycle. The pitch path sets the depth: four stages for the quaternion
// product and the trigonometric operands, one for the square of the pitch
// sine, 31 stages of bit-per-step square root, 1 + CORDIC_STAGES CORDIC
// stages, and the output register. Roll and yaw run their CORDIC early and
// wait in delay lines. Mounting registers are written through the plain
// write port; the user must do so only while the block is idle, which the
// block does not enforce. After reset they hold a -90 degree turn about y.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles (
  input  logic                           clk,
  input  logic                           rst,
  qte_quat_if.sink                       quat,
  qte_euler_if.source                    euler,
  input  logic                           cfg_wr_en,
  input  logic [qte_pkg::CFG_IW-1:0]     cfg_index,
  input  logic signed [qte_pkg::IW-1:0]  cfg_data
);
  import qte_pkg::*;

  localparam int DLY  = SQ_STEPS + 1;
  localparam int SATN = SQ_STEPS + 2 + CORDIC_STAGES;
  localparam int LAT  = 38 + CORDIC_STAGES;

  // mounting quaternion
  logic signed [IW-1:0] mount_qx, mount_qy, mount_qz, mount_qw;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_qx <= 16'sd0;
      mount_qy <= -16'sd23170;
      mount_qz <= 16'sd0;
      mount_qw <= 16'sd23170;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MOUNT_QX: mount_qx <= cfg_data;
        CFG_MOUNT_QY: mount_qy <= cfg_data;
        CFG_MOUNT_QZ: mount_qz <= cfg_data;
        CFG_MOUNT_QW: mount_qw <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: advance unless a result is held at the output
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv        = !vld[LAT-1] || euler.ready;
  assign quat.ready = adv;
  assign euler.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], quat.valid};
    end
  end

  // stage 1: remap to (-z, -x, y, w) and form all sixteen partial products
  logic signed [AW-1:0]  ax, ay, az, aw;
  logic signed [PRW-1:0] pr [16];

  assign ax = -(AW'(quat.quat_z));
  assign ay = -(AW'(quat.quat_x));
  assign az = AW'(quat.quat_y);
  assign aw = AW'(quat.quat_w);

  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0]  <= PRW'(aw) * PRW'(mount_qx);
      pr[1]  <= PRW'(ax) * PRW'(mount_qw);
      pr[2]  <= PRW'(ay) * PRW'(mount_qz);
      pr[3]  <= PRW'(az) * PRW'(mount_qy);
      pr[4]  <= PRW'(aw) * PRW'(mount_qy);
      pr[5]  <= PRW'(ax) * PRW'(mount_qz);
      pr[6]  <= PRW'(ay) * PRW'(mount_qw);
      pr[7]  <= PRW'(az) * PRW'(mount_qx);
      pr[8]  <= PRW'(aw) * PRW'(mount_qz);
      pr[9]  <= PRW'(ax) * PRW'(mount_qy);
      pr[10] <= PRW'(ay) * PRW'(mount_qx);
      pr[11] <= PRW'(az) * PRW'(mount_qw);
      pr[12] <= PRW'(aw) * PRW'(mount_qw);
      pr[13] <= PRW'(ax) * PRW'(mount_qx);
      pr[14] <= PRW'(ay) * PRW'(mount_qy);
      pr[15] <= PRW'(az) * PRW'(mount_qz);
    end
  end

  // stage 2: Hamilton product, rounded back to 15 fraction bits
  logic signed [SUMW-1:0] sx, sy_s, sz, sw;
  logic signed [PW-1:0]   px, py, pz, pw;

  assign sx   = SUMW'(pr[0]) + SUMW'(pr[1]) + SUMW'(pr[2]) - SUMW'(pr[3])
              + SUMW'(16384);
  assign sy_s = SUMW'(pr[4]) - SUMW'(pr[5]) + SUMW'(pr[6]) + SUMW'(pr[7])
              + SUMW'(16384);
  assign sz   = SUMW'(pr[8]) + SUMW'(pr[9]) - SUMW'(pr[10]) + SUMW'(pr[11])
              + SUMW'(16384);
  assign sw   = SUMW'(pr[12]) - SUMW'(pr[13]) - SUMW'(pr[14]) - SUMW'(pr[15])
              + SUMW'(16384);

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= PW'(sx >>> 15);
      py <= PW'(sy_s >>> 15);
      pz <= PW'(sz >>> 15);
      pw <= PW'(sw >>> 15);
    end
  end

  // stage 3: component products
  logic signed [PPW-1:0] q_wx, q_yz, q_xx, q_yy, q_wy, q_zx, q_wz, q_xy, q_zz;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_wx <= PPW'(pw) * PPW'(px);
      q_yz <= PPW'(py) * PPW'(pz);
      q_xx <= PPW'(px) * PPW'(px);
      q_yy <= PPW'(py) * PPW'(py);
      q_wy <= PPW'(pw) * PPW'(py);
      q_zx <= PPW'(pz) * PPW'(px);
      q_wz <= PPW'(pw) * PPW'(pz);
      q_xy <= PPW'(px) * PPW'(py);
      q_zz <= PPW'(pz) * PPW'(pz);
    end
  end

  // stage 4: atan2 and asin operands, 30 fraction bits
  logic signed [OPW-1:0] sr, cr, sp, syw, cyw;

  always_ff @(posedge clk) begin
    if (adv) begin
      sr  <= (OPW'(q_wx) + OPW'(q_yz)) <<< 1;
      cr  <= ONE_Q30 - ((OPW'(q_xx) + OPW'(q_yy)) <<< 1);
      sp  <= (OPW'(q_wy) - OPW'(q_zx)) <<< 1;
      syw <= (OPW'(q_wz) + OPW'(q_xy)) <<< 1;
      cyw <= ONE_Q30 - ((OPW'(q_yy) + OPW'(q_zz)) <<< 1);
    end
  end

  // stage 5: radicand 1 - s^2, saturation detect, start of the delay lines
  logic                  sat_now, pos_now;
  logic [29:0]           s_abs;
  logic [59:0]           s_sq;
  logic [RW-1:0]         rem;
  logic signed [OPW-1:0] s_dly [DLY];
  logic [1:0]            sat_dly [SATN];

  assign sat_now = (sp >= ONE_Q30) || (sp <= -ONE_Q30);
  assign pos_now = sp > 0;
  assign s_abs   = (sp < 0) ? 30'(-sp) : 30'(sp);
  assign s_sq    = 60'(s_abs) * 60'(s_abs);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem        <= (RW'(1) << 60) - RW'(s_sq);
      s_dly[0]   <= sp;
      sat_dly[0] <= {sat_now, pos_now};
      for (int k = 1; k < DLY; k++) s_dly[k] <= s_dly[k-1];
      for (int k = 1; k < SATN; k++) sat_dly[k] <= sat_dly[k-1];
    end
  end

  // cos(pitch) from the square root, lined up with the delayed sine
  logic [SW-1:0] c_sq;

  qte_isqrt u_isqrt (
    .clk   (clk),
    .en    (adv),
    .n_in  (rem),
    .r_out (c_sq)
  );

  // three CORDIC lanes
  logic signed [ZW-1:0] z_roll, z_yaw, z_pitch;

  qte_cordic u_roll (
    .clk   (clk),
    .en    (adv),
    .x_in  (CW'(cr)),
    .y_in  (CW'(sr)),
    .z_out (z_roll)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .en    (adv),
    .x_in  (CW'(cyw)),
    .y_in  (CW'(syw)),
    .z_out (z_yaw)
  );

  qte_cordic u_pitch (
    .clk   (clk),
    .en    (adv),
    .x_in  (CW'($signed({1'b0, c_sq}))),
    .y_in  (CW'(s_dly[DLY-1])),
    .z_out (z_pitch)
  );

  // hold roll and yaw until pitch catches up
  logic signed [ZW-1:0] zr_dly [DLY];
  logic signed [ZW-1:0] zy_dly [DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      zr_dly[0] <= z_roll;
      zy_dly[0] <= z_yaw;
      for (int k = 1; k < DLY; k++) begin
        zr_dly[k] <= zr_dly[k-1];
        zy_dly[k] <= zy_dly[k-1];
      end
    end
  end

  // output register: round to Q3.13, clamp, negate pitch
  logic signed [ZW-1:0] roll_c, yaw_c, pitch_c;
  logic                 sat_end, pos_end;

  assign roll_c  = clamp_ang(to_q13(zr_dly[DLY-1]), ANG_MAX);
  assign yaw_c   = clamp_ang(to_q13(zy_dly[DLY-1]), ANG_MAX);
  assign pitch_c = clamp_ang(to_q13(z_pitch), HALF_PI_Q13);
  assign sat_end = sat_dly[SATN-1][1];
  assign pos_end = sat_dly[SATN-1][0];

  always_ff @(posedge clk) begin
    if (adv) begin
      euler.roll_angle      <= ANGW'(roll_c);
      euler.yaw_angle       <= ANGW'(yaw_c);
      euler.pitch_saturated <= sat_end;
      if (sat_end) begin
        euler.pitch_angle <= pos_end ? PITW'(-HALF_PI_Q13) : PITW'(HALF_PI_Q13);
      end else begin
        euler.pitch_angle <= PITW'(-pitch_c);
      end
    end
  end

  `QTE_ASSERT(a_pitch_range, euler.valid |-> (euler.pitch_angle <= 15'sd12868 && euler.pitch_angle >= -15'sd12868))
  `QTE_ASSERT(a_sat_clamp, (euler.valid && euler.pitch_saturated) |-> (euler.pitch_angle == 15'sd12868 || euler.pitch_angle == -15'sd12868))
  `QTE_ASSERT(a_roll_range, euler.valid |-> (euler.roll_angle <= 16'sd25736 && euler.roll_angle >= -16'sd25736))
  `QTE_ASSERT_NEXT(a_enter, quat.valid && quat.ready, vld[0])
  `QTE_ASSERT(a_hold, (euler.valid && !euler.ready) |-> !quat.ready)

endmodule

// File: bench/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: quaternion to Euler angles
// Drives sensor quaternions under several mounting rotations with random
// gaps and output stalls. Every result is checked against a bit-exact
// predictor of the remap, the quaternion product and the CORDIC angles.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;
  import qte_pkg::*;

  localparam int RAND_ITEMS  = 500;
  localparam int DRAIN_WAIT  = 80;       // more than the pipeline's default depth
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [ANGW-1:0] roll;
    logic signed [PITW-1:0] pitch;
    logic signed [ANGW-1:0] yaw;
    logic                   sat;
  } euler_t;

  // One directed stimulus row. mount_set selects a mounting rotation; when
  // pinned, pitch and the saturation flag are typed in and also checked.
  typedef struct {
    int                   mount_set;
    logic signed [IW-1:0] qx, qy, qz, qw;
    bit                   pinned;
    logic signed [PITW-1:0] pin_pitch;
    logic                 pin_sat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic signed [IW-1:0] cfg_data = '0;

  qte_quat_if  quat_ch ();
  qte_euler_if euler_ch ();

  quaternion_to_euler_angles dut (
    .clk       (clk),
    .rst       (rst),
    .quat      (quat_ch.sink),
    .euler     (euler_ch.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the mounting quaternion (x, y, z, w).
  longint mount_q [4];
  euler_t angles_due [$];
  int     fail_count = 0;
  int     cycle_count = 0;

  stim_row_t stim_table [] = '{
    // reset mount: a -90 degree turn about y
    '{0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0, '0, 1'b0},
    '{0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 0, '0, 1'b0},
    '{0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 0, '0, 1'b0},
    '{0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 0, '0, 1'b0},
    '{0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 0, '0, 1'b0},
    '{0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, '0, 1'b0},
    '{0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0, '0, 1'b0},
    '{0, 16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 0, '0, 1'b0},
    '{0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 0, '0, 1'b0},
    // near-identity mount: sine of pitch past one clamps the pitch
    '{1, -16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 1, -15'sd12868, 1'b1},
    '{1, 16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 1, 15'sd12868, 1'b1},
    '{1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0, '0, 1'b0},
    '{1, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 0, '0, 1'b0},
    '{1, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 0, '0, 1'b0},
    '{1, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 0, '0, 1'b0},
    '{1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 0, '0, 1'b0},
    // extreme negative mount
    '{2, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0, '0, 1'b0},
    '{2, -16'sd32768, 16'sd0, 16'sd32767, 16'sd1, 0, '0, 1'b0},
    '{2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0, '0, 1'b0},
    // extreme positive mount
    '{3, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, '0, 1'b0},
    '{3, 16'sd12000, -16'sd5000, 16'sd30000, -16'sd20000, 0, '0, 1'b0},
    '{3, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 0, '0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, angle with 28 fraction bits.
  function automatic longint arctan2_q28(input longint y, input longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_entry(i));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_entry(i));
      end
    end
    return z;
  endfunction

  function automatic longint angle_q13(input longint z, input longint lim);
    longint v;
    v = (z + 16384) >>> 15;
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic euler_t euler_of(input logic signed [IW-1:0] qx, qy, qz, qw);
    longint ax, ay, az, aw, mx, my, mz, mw, px, py, pz, pw, s, c, v;
    euler_t r;
    // remap (x,y,z,w) -> (-z,-x,y,w)
    ax = -longint'(qz); ay = -longint'(qx); az = longint'(qy); aw = longint'(qw);
    mx = mount_q[0]; my = mount_q[1]; mz = mount_q[2]; mw = mount_q[3];
    px = (aw * mx + ax * mw + ay * mz - az * my + 16384) >>> 15;
    py = (aw * my - ax * mz + ay * mw + az * mx + 16384) >>> 15;
    pz = (aw * mz + ax * my - ay * mx + az * mw + 16384) >>> 15;
    pw = (aw * mw - ax * mx - ay * my - az * mz + 16384) >>> 15;
    v = angle_q13(arctan2_q28(2 * (pw * px + py * pz),
                              (64'sd1 << 30) - 2 * (px * px + py * py)), 25736);
    r.roll = v[ANGW-1:0];
    s = 2 * (pw * py - pz * px);
    if (s >= (64'sd1 << 30) || s <= -(64'sd1 << 30)) begin
      r.sat = 1'b1;
      v = (s > 0) ? -12868 : 12868;
    end else begin
      r.sat = 1'b0;
      c = longint'(int_sqrt((64'd1 << 60) - longint'(s * s)));
      v = -angle_q13(arctan2_q28(s, c), 12868);
    end
    r.pitch = v[PITW-1:0];
    v = angle_q13(arctan2_q28(2 * (pw * pz + px * py),
                              (64'sd1 << 30) - 2 * (py * py + pz * pz)), 25736);
    r.yaw = v[ANGW-1:0];
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready with stall stretches, check each transfer
  // --------------------------------------------------------------------------
  initial euler_ch.ready = 1'b0;

  always @(negedge clk) begin
    int roll_dice;
    roll_dice = $urandom_range(0, 99);
    if (rst) euler_ch.ready <= 1'b0;
    else if ((cycle_count / 300) % 3 == 0) euler_ch.ready <= 1'b1;   // no stalls
    else if (roll_dice < 3) euler_ch.ready <= 1'b0;                  // start long stall
    else if (!euler_ch.ready && roll_dice < 12) euler_ch.ready <= 1'b0;
    else euler_ch.ready <= (roll_dice < 75);
  end

  always @(posedge clk) begin
    euler_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && euler_ch.valid && euler_ch.ready) begin
      if (angles_due.size() == 0) begin
        report("result with nothing expected", 1, 0);
      end else begin
        want = angles_due.pop_front();
        if (euler_ch.roll_angle !== want.roll)
          report("roll_angle", euler_ch.roll_angle, want.roll);
        if (euler_ch.pitch_angle !== want.pitch)
          report("pitch_angle", euler_ch.pitch_angle, want.pitch);
        if (euler_ch.yaw_angle !== want.yaw)
          report("yaw_angle", euler_ch.yaw_angle, want.yaw);
        if (euler_ch.pitch_saturated !== want.sat)
          report("pitch_saturated", euler_ch.pitch_saturated, want.sat);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Quaternion side
  // --------------------------------------------------------------------------
  initial begin
    quat_ch.valid = 1'b0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    quat_ch.quat_w = '0;
  end

  // Hold the item until its transfer, then queue its expected angles.
  task automatic send_quat(input logic signed [IW-1:0] qx, qy, qz, qw);
    int gap, pick;
    pick = $urandom_range(0, 99);
    if ((cycle_count / 250) % 4 == 0) gap = 0;      // stretch with no gaps
    else if (pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    repeat (gap) @(negedge clk) quat_ch.valid <= 1'b0;
    @(negedge clk);
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_x <= qx;
    quat_ch.quat_y <= qy;
    quat_ch.quat_z <= qz;
    quat_ch.quat_w <= qw;
    do @(posedge clk); while (!quat_ch.ready);
    angles_due.push_back(euler_of(qx, qy, qz, qw));
  endtask

  // Wait until every result is back, then let the pipeline go quiet.
  task automatic drain();
    @(negedge clk) quat_ch.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_mount(input longint qx, qy, qz, qw);
    longint vals [4];
    vals = '{qx, qy, qz, qw};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i][IW-1:0];
      mount_q[i] = longint'($signed(vals[i][IW-1:0]));
    end
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [IW-1:0] rand_comp();
    return IW'($urandom_range(0, 65535));
  endfunction

  initial begin
    int cur_set;
    logic signed [IW-1:0] rx, ry, rz, rw;
    longint m [4];
    euler_t pin_check;
    mount_q = '{0, -23170, 0, 23170};
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed rows, grouped by mounting rotation.
    cur_set = 0;
    foreach (stim_table[k]) begin
      if (stim_table[k].mount_set != cur_set) begin
        drain();
        cur_set = stim_table[k].mount_set;
        case (cur_set)
          1: write_mount(0, 0, 0, 32767);
          2: write_mount(-32768, -32768, -32768, -32768);
          default: write_mount(32767, 32767, 32767, 32767);
        endcase
      end
      if (stim_table[k].pinned) begin
        pin_check = euler_of(stim_table[k].qx, stim_table[k].qy,
                             stim_table[k].qz, stim_table[k].qw);
        if (pin_check.pitch !== stim_table[k].pin_pitch)
          report("typed pitch_angle", pin_check.pitch, stim_table[k].pin_pitch);
        if (pin_check.sat !== stim_table[k].pin_sat)
          report("typed pitch_saturated", pin_check.sat, stim_table[k].pin_sat);
      end
      send_quat(stim_table[k].qx, stim_table[k].qy, stim_table[k].qz, stim_table[k].qw);
    end

    // Random items in five phases, a mounting rotation written for each.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: m[i] = longint'($signed(16'($urandom_range(0, 65535))));
          1: m[i] = $urandom_range(0, 1) ? 32767 : -32768;
          default: m[i] = longint'($urandom_range(0, 46340)) - 23170;
        endcase
      end
      if (ph == 0) m = '{0, -23170, 0, 23170};   // back to the reset rotation
      write_mount(m[0], m[1], m[2], m[3]);
      for (int n = 0; n < RAND_ITEMS / 5; n++) begin
        if ($urandom_range(0, 1)) begin
          rx = rand_comp(); ry = rand_comp(); rz = rand_comp(); rw = rand_comp();
        end else begin
          // components within plus or minus one half, so the norm is at most one
          rx = IW'(longint'($urandom_range(0, 32768)) - 16384);
          ry = IW'(longint'($urandom_range(0, 32768)) - 16384);
          rz = IW'(longint'($urandom_range(0, 32768)) - 16384);
          rw = IW'(longint'($urandom_range(0, 32768)) - 16384);
        end
        send_quat(rx, ry, rz, rw);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/qte_pkg.sv
rtl/qte_channels.sv
rtl/qte_cordic.sv
rtl/qte_isqrt.sv
rtl/quaternion_to_euler_angles.sv
bench/tb_quaternion_to_euler_angles.sv
